@@ hdl/lrbs_pkg.sv @@
package lrbs_pkg;

  localparam int unsigned BandCountDefault = 16;

  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 16;

  localparam logic [CfgIdxW-1:0] CfgInvert = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgChips  = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgTicks  = 2'd2;

  localparam logic [1:0] ChipsNibble = 2'd1;
  localparam logic [1:0] ChipsByte   = 2'd2;

  localparam logic [9:0] ClampNibble = 10'd15;
  localparam logic [9:0] ClampByte   = 10'd255;

  localparam logic [1:0] ChipCountReset = 2'd2;
  localparam logic [15:0] TicksReset    = 16'd20;

  typedef enum logic [1:0] {
    OP_TICK   = 2'd0,
    OP_SELECT = 2'd1,
    OP_SET    = 2'd2,
    OP_STEP   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic accept;
    logic apply_recall;
  } cmd_t;

  typedef struct packed {
    logic recall;
  } status_t;

  // relay bit i set drives coil 2i, clear drives coil 2i+1; invert swaps the pair
  function automatic logic [15:0] expand_coils(input logic [7:0] value, input logic invert);
    logic [7:0] v;
    logic [15:0] w;
    v = invert ? ~value : value;
    w = '0;
    for (int i = 0; i < 8; i++) begin
      w[2*i]   = v[i];
      w[2*i+1] = ~v[i];
    end
    return w;
  endfunction

endpackage

@@ hdl/lrbs_ctrl.sv @@
module lrbs_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  lrbs_pkg::status_t status_i,
  output lrbs_pkg::cmd_t    cmd_o
);

  lrbs_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lrbs_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      lrbs_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          state_d = status_i.recall ? lrbs_pkg::ST_READ : lrbs_pkg::ST_OUT;
        end
      end
      lrbs_pkg::ST_READ: begin
        state_d = lrbs_pkg::ST_OUT;
      end
      lrbs_pkg::ST_OUT: begin
        if (out_ready_i) begin
          state_d = lrbs_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = lrbs_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready_o         = 1'b0;
    out_valid_o        = 1'b0;
    cmd_o.accept       = 1'b0;
    cmd_o.apply_recall = 1'b0;
    case (state_q)
      lrbs_pkg::ST_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
      end
      lrbs_pkg::ST_READ: begin
        cmd_o.apply_recall = 1'b1;
      end
      lrbs_pkg::ST_OUT: begin
        out_valid_o = 1'b1;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

endmodule

@@ hdl/lrbs_dpath.sv @@
module lrbs_dpath #(
  parameter int unsigned BAND_COUNT = lrbs_pkg::BandCountDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [lrbs_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [lrbs_pkg::CfgDataW-1:0] cfg_data_i,
  input  lrbs_pkg::cmd_t                cmd_i,
  output lrbs_pkg::status_t             status_o,
  input  logic [1:0]                    operation_i,
  input  logic [3:0]                    band_index_i,
  input  logic [7:0]                    set_value_i,
  input  logic signed [8:0]             step_amount_i,
  output logic [15:0]                   coil_word_o,
  output logic [7:0]                    relay_value_o,
  output logic [3:0]                    current_band_o,
  output logic                          busy_res_o,
  output logic                          rejected_o
);

  localparam int unsigned BandAw = (BAND_COUNT > 1) ? $clog2(BAND_COUNT) : 1;
  localparam logic [8:0] BandLimit = 9'(BAND_COUNT);

  logic        invert_q;
  logic [1:0]  chips_q;
  logic [15:0] ticks_q;

  logic [7:0]  value_q, value_d;
  logic [3:0]  band_q, band_d;
  logic [15:0] drive_q, drive_d;
  logic [15:0] pulse_q, pulse_d;
  logic        rejected_q, rejected_d;

  logic [7:0]  band_mem [BAND_COUNT];
  logic [BAND_COUNT-1:0] stored_q;
  logic [7:0]  rd_data_q;
  logic        rd_hit_q;

  lrbs_pkg::op_e op;
  logic        busy;
  logic        band_ok;
  logic        apply_en;
  logic [7:0]  apply_val;
  logic [7:0]  stepped;
  logic signed [9:0] step_sum;
  logic [9:0]  clamp_top;
  logic [15:0] pulse_dec;
  logic [BandAw-1:0] rd_addr;
  logic [BandAw-1:0] wr_addr;

  assign op      = lrbs_pkg::op_e'(operation_i);
  assign busy    = (pulse_q != 16'd0);
  assign band_ok = ({5'd0, band_index_i} < BandLimit);
  assign rd_addr = BandAw'(band_index_i);
  assign wr_addr = BandAw'(band_q);

  assign status_o.recall = (op == lrbs_pkg::OP_SELECT) && !busy && band_ok;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      invert_q <= 1'b0;
      chips_q  <= lrbs_pkg::ChipCountReset;
      ticks_q  <= lrbs_pkg::TicksReset;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        lrbs_pkg::CfgInvert: invert_q <= cfg_data_i[0];
        lrbs_pkg::CfgChips:  chips_q  <= cfg_data_i[1:0];
        lrbs_pkg::CfgTicks:  ticks_q  <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // relative step, clamped by the chip count; a chip count other than nibble or byte holds the value
  assign step_sum  = $signed({2'b00, value_q}) + $signed({step_amount_i[8], step_amount_i});
  assign clamp_top = (chips_q == lrbs_pkg::ChipsNibble) ? lrbs_pkg::ClampNibble
                                                        : lrbs_pkg::ClampByte;
  always_comb begin
    if (chips_q == lrbs_pkg::ChipsNibble || chips_q == lrbs_pkg::ChipsByte) begin
      if (step_sum[9]) begin
        stepped = 8'd0;
      end else if (10'(step_sum) > clamp_top) begin
        stepped = clamp_top[7:0];
      end else begin
        stepped = step_sum[7:0];
      end
    end else begin
      stepped = value_q;
    end
  end

  always_comb begin
    apply_en  = cmd_i.apply_recall;
    apply_val = rd_hit_q ? rd_data_q : 8'd0;
    if (cmd_i.accept && !busy) begin
      if (op == lrbs_pkg::OP_SET) begin
        apply_en  = 1'b1;
        apply_val = set_value_i;
      end else if (op == lrbs_pkg::OP_STEP) begin
        apply_en  = 1'b1;
        apply_val = stepped;
      end
    end
  end

  assign pulse_dec = pulse_q - 16'd1;

  always_comb begin
    value_d    = value_q;
    band_d     = band_q;
    drive_d    = drive_q;
    pulse_d    = pulse_q;
    rejected_d = rejected_q;
    if (cmd_i.accept) begin
      rejected_d = (op != lrbs_pkg::OP_TICK) &&
                   (busy || (op == lrbs_pkg::OP_SELECT && !band_ok));
      if (op == lrbs_pkg::OP_TICK && busy) begin
        pulse_d = pulse_dec;
        if (pulse_dec == 16'd0) begin
          drive_d = 16'd0;
        end
      end
      if (status_o.recall) begin
        band_d = band_index_i;
      end
    end
    if (apply_en) begin
      value_d = apply_val;
      pulse_d = ticks_q;
      drive_d = (ticks_q != 16'd0) ? lrbs_pkg::expand_coils(apply_val, invert_q) : 16'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      value_q    <= 8'd0;
      band_q     <= 4'd0;
      drive_q    <= 16'd0;
      pulse_q    <= 16'd0;
      rejected_q <= 1'b0;
      stored_q   <= '0;
    end else begin
      value_q    <= value_d;
      band_q     <= band_d;
      drive_q    <= drive_d;
      pulse_q    <= pulse_d;
      rejected_q <= rejected_d;
      if (apply_en) begin
        stored_q[wr_addr] <= 1'b1;
      end
    end
  end

  // band store: written on every new value, read once per band select
  always_ff @(posedge clk_i) begin
    if (apply_en) begin
      band_mem[wr_addr] <= apply_val;
    end
    if (cmd_i.accept && status_o.recall) begin
      rd_data_q <= band_mem[rd_addr];
      rd_hit_q  <= stored_q[rd_addr];
    end
  end

  assign coil_word_o    = drive_q;
  assign relay_value_o  = value_q;
  assign current_band_o = band_q;
  assign busy_res_o     = busy;
  assign rejected_o     = rejected_q;

endmodule

@@ hdl/latching_relay_bank_sequencer.sv @@
// channel   handshake                  payload
// in        in_valid_i / in_ready_o    operation_i band_index_i set_value_i step_amount_i
// out       out_valid_o / out_ready_i  coil_word_o relay_value_o current_band_o
//                                      busy_res_o rejected_o
// cfg       cfg_valid_i / cfg_ready_o  cfg_index_i cfg_data_i
//
// one item in flight: a tick, set, step or rejected command shows its result the cycle
// after it is taken, a band select only after the extra ST_READ state for the registered
// band store read. in_ready_o is low from the accepting edge until the result is taken.
// reset clears the control and relay state and the band stored flags, not the band store,
// and loads the config defaults; config writes are always taken.
module latching_relay_bank_sequencer #(
  parameter int unsigned BAND_COUNT = lrbs_pkg::BandCountDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [lrbs_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [lrbs_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [1:0]                    operation_i,
  input  logic [3:0]                    band_index_i,
  input  logic [7:0]                    set_value_i,
  input  logic signed [8:0]             step_amount_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [15:0]                   coil_word_o,
  output logic [7:0]                    relay_value_o,
  output logic [3:0]                    current_band_o,
  output logic                          busy_res_o,
  output logic                          rejected_o
);

  lrbs_pkg::cmd_t    cmd;
  lrbs_pkg::status_t status;

  assign cfg_ready_o = 1'b1;

  lrbs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  lrbs_dpath #(
    .BAND_COUNT (BAND_COUNT)
  ) u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_valid_i && cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .cmd_i          (cmd),
    .status_o       (status),
    .operation_i    (operation_i),
    .band_index_i   (band_index_i),
    .set_value_i    (set_value_i),
    .step_amount_i  (step_amount_i),
    .coil_word_o    (coil_word_o),
    .relay_value_o  (relay_value_o),
    .current_band_o (current_band_o),
    .busy_res_o     (busy_res_o),
    .rejected_o     (rejected_o)
  );

  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o)
    else $error("input taken while a result waits");

  a_direct_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && !status.recall) |=> out_valid_o)
    else $error("result missing after a direct item");

  a_recall_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && status.recall) |=> (!out_valid_o && cmd.apply_recall))
    else $error("band select did not wait for the store read");

  a_idle_coils: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !busy_res_o) |-> (coil_word_o == 16'd0))
    else $error("coil word driven with no pulse running");

endmodule

@@ test/latching_relay_bank_sequencer_test.sv @@
module latching_relay_bank_sequencer_test;
  import lrbs_pkg::*;

  localparam int unsigned BANDS = BandCountDefault;
  localparam int StallLimit = 4000;

  typedef struct packed {
    logic [15:0] coil;
    logic [7:0]  value;
    logic [3:0]  band;
    logic        busy;
    logic        rejected;
  } relay_outcome_t;

  typedef struct {
    logic        invert;
    logic [1:0]  chips;
    logic [15:0] ticks;
  } relay_setting_t;

  // tracks the relay bank and holds the outcomes still owed by the block
  class relay_bank_tracker;
    logic        invert;
    logic [1:0]  chips;
    logic [15:0] ticks;
    logic [7:0]  value_now;
    logic [3:0]  band_now;
    logic [15:0] drive;
    logic [15:0] pulse_left;
    logic [7:0]  saved [BANDS];
    bit          stored [BANDS];
    relay_outcome_t due_outcomes[$];
    int mismatches;

    function new();
      invert = 1'b0;
      chips = ChipCountReset;
      ticks = TicksReset;
      value_now = '0;
      band_now = '0;
      drive = '0;
      pulse_left = '0;
      mismatches = 0;
      foreach (stored[i]) begin
        stored[i] = 1'b0;
        saved[i] = '0;
      end
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
      case (idx)
        CfgInvert: invert = data[0];
        CfgChips:  chips = data[1:0];
        CfgTicks:  ticks = data;
        default: ;
      endcase
    endfunction

    function logic [15:0] coils_for(logic [7:0] v);
      logic [7:0]  bits;
      logic [15:0] w;
      bits = invert ? ~v : v;
      for (int i = 0; i < 8; i++) begin
        w[2*i]   = bits[i];
        w[2*i+1] = !bits[i];
      end
      return w;
    endfunction

    function void latch_value(logic [7:0] v);
      value_now = v;
      if (band_now < BANDS) begin
        saved[band_now] = v;
        stored[band_now] = 1'b1;
      end
      pulse_left = ticks;
      drive = (pulse_left != 0) ? coils_for(v) : '0;
    endfunction

    function void take_command(op_e op, logic [3:0] band, logic [7:0] setv,
                               logic signed [8:0] step);
      relay_outcome_t o;
      logic rej;
      int nxt;
      int top;
      rej = 1'b0;
      if (op == OP_TICK) begin
        if (pulse_left != 0) begin
          pulse_left--;
          if (pulse_left == 0) drive = '0;
        end
      end else if (pulse_left != 0) begin
        rej = 1'b1;
      end else begin
        case (op)
          OP_SELECT: begin
            if (band >= BANDS) begin
              rej = 1'b1;
            end else begin
              band_now = band;
              latch_value(stored[band] ? saved[band] : 8'd0);
            end
          end
          OP_SET: latch_value(setv);
          default: begin
            nxt = int'(value_now) + int'(step);
            if (chips == ChipsNibble || chips == ChipsByte) begin
              top = (chips == ChipsNibble) ? int'(ClampNibble) : int'(ClampByte);
              if (nxt < 0) nxt = 0;
              if (nxt > top) nxt = top;
            end else begin
              nxt = int'(value_now);
            end
            latch_value(8'(nxt));
          end
        endcase
      end
      o.coil = drive;
      o.value = value_now;
      o.band = band_now;
      o.busy = (pulse_left != 0);
      o.rejected = rej;
      due_outcomes.push_back(o);
    endfunction

    function void note_field(string name, int want, int got);
      if (want != got) begin
        mismatches++;
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      end
    endfunction

    function void match_outcome(relay_outcome_t got);
      relay_outcome_t want;
      if (due_outcomes.size() == 0) begin
        mismatches++;
        $display("%0t: result with nothing expected, expected none, actual %p", $time, got);
        return;
      end
      want = due_outcomes.pop_front();
      note_field("coil_word", want.coil, got.coil);
      note_field("relay_value", want.value, got.value);
      note_field("current_band", want.band, got.band);
      note_field("busy_res", want.busy, got.busy);
      note_field("rejected", want.rejected, got.rejected);
    endfunction

    function int outstanding();
      return due_outcomes.size();
    endfunction
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;
  logic                in_valid_i = 1'b0;
  logic                in_ready_o;
  logic [1:0]          operation_i = '0;
  logic [3:0]          band_index_i = '0;
  logic [7:0]          set_value_i = '0;
  logic signed [8:0]   step_amount_i = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  logic [15:0]         coil_word_o;
  logic [7:0]          relay_value_o;
  logic [3:0]          current_band_o;
  logic                busy_res_o;
  logic                rejected_o;

  relay_bank_tracker tracker;
  int in_idle_pct = 0;
  int out_idle_pct = 0;
  int stall_cycles = 0;
  relay_setting_t plan [6] = '{
    '{1'b1, 2'd1, 16'd3},
    '{1'b0, 2'd0, 16'd0},
    '{1'b1, 2'd3, 16'd1},
    '{1'b0, 2'd2, 16'd65535},
    '{1'b1, 2'd2, 16'd0},
    '{1'b0, 2'd1, 16'd7}
  };

  latching_relay_bank_sequencer DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .operation_i   (operation_i),
    .band_index_i  (band_index_i),
    .set_value_i   (set_value_i),
    .step_amount_i (step_amount_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .coil_word_o   (coil_word_o),
    .relay_value_o (relay_value_o),
    .current_band_o(current_band_o),
    .busy_res_o    (busy_res_o),
    .rejected_o    (rejected_o)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= out_idle_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) tracker.write_reg(cfg_index_i, cfg_data_i);
      if (in_valid_i && in_ready_o) begin
        tracker.take_command(op_e'(operation_i), band_index_i, set_value_i, step_amount_i);
      end
      if (out_valid_o && out_ready_i) begin
        tracker.match_outcome('{coil_word_o, relay_value_o, current_band_o,
                                busy_res_o, rejected_o});
      end
    end
  end

  // nothing moving on any channel for too long means a hang
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((cfg_valid_i && cfg_ready_o) || (in_valid_i && in_ready_o) ||
          (out_valid_o && out_ready_i)) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= StallLimit) begin
        $display("latching_relay_bank_sequencer_test failed");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  task automatic send_item(op_e op, logic [3:0] band, logic [7:0] setv, logic [8:0] step);
    if ($urandom_range(99) < in_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(negedge clk_i); while ($urandom_range(99) < in_idle_pct);
    end
    in_valid_i <= 1'b1;
    operation_i <= op;
    band_index_i <= band;
    set_value_i <= setv;
    step_amount_i <= step;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (tracker.outstanding() != 0) @(negedge clk_i);
  endtask

  task automatic apply_setting(relay_setting_t s);
    logic [CfgDataW-1:0] data [3];
    data[CfgInvert] = CfgDataW'(s.invert);
    data[CfgChips] = CfgDataW'(s.chips);
    data[CfgTicks] = s.ticks;
    wait_drained();
    for (int i = 0; i < 3; i++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= CfgIdxW'(i);
      cfg_data_i <= data[i];
      do @(posedge clk_i); while (!cfg_ready_o);
      @(negedge clk_i);
    end
    cfg_valid_i <= 1'b0;
  endtask

  task automatic drain_pulse();
    while (tracker.pulse_left != 0) send_item(OP_TICK, '0, '0, '0);
  endtask

  task automatic random_item();
    op_e op;
    int pick;
    logic [8:0] step;
    pick = $urandom_range(99);
    // while a pulse runs mostly tick it down, with some commands to be rejected
    if (tracker.pulse_left != 0 && pick < 85) op = OP_TICK;
    else if (pick % 20 < 3) op = OP_TICK;
    else if (pick % 20 < 7) op = OP_SELECT;
    else if (pick % 20 < 13) op = OP_SET;
    else op = OP_STEP;
    if ($urandom_range(1)) step = 9'(int'($urandom_range(40)) - 20);
    else step = 9'($urandom_range(511));
    send_item(op, 4'($urandom_range(15)), 8'($urandom_range(255)), step);
  endtask

  initial begin
    tracker = new();
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    in_idle_pct = 36;
    out_idle_pct = 60;
    apply_setting('{1'b0, ChipsNibble, 16'd2});
    send_item(OP_TICK, '0, '0, '0);
    send_item(OP_SET, '0, 8'hA5, '0);
    send_item(OP_SET, '0, 8'h00, '0);
    send_item(OP_SELECT, 4'd15, '0, '0);
    send_item(OP_STEP, '0, '0, 9'd1);
    drain_pulse();
    send_item(OP_TICK, '0, '0, '0);
    // value above the nibble clamp is pulled back by a step
    send_item(OP_STEP, '0, '0, 9'h0FF);
    drain_pulse();
    send_item(OP_STEP, '0, '0, 9'h100);
    drain_pulse();
    send_item(OP_SELECT, 4'd15, '0, '0);
    drain_pulse();
    send_item(OP_SET, '0, 8'hFF, '0);
    drain_pulse();
    send_item(OP_SELECT, 4'd0, '0, '0);
    drain_pulse();
    send_item(OP_SELECT, 4'd15, '0, '0);
    drain_pulse();

    for (int mode = 0; mode < 3; mode++) begin
      in_idle_pct = (mode == 0) ? 36 : (mode == 1) ? 60 : 0;
      out_idle_pct = (mode == 0) ? 60 : (mode == 1) ? 36 : 0;
      foreach (plan[p]) begin
        apply_setting(plan[p]);
        for (int n = 0; n < 80; n++) begin
          if ($urandom_range(99) == 0) wait_drained();
          random_item();
        end
      end
    end

    wait_drained();
    repeat (12) @(negedge clk_i);
    if (tracker.mismatches == 0 && tracker.outstanding() == 0) begin
      $display("latching_relay_bank_sequencer_test passed");
    end else begin
      $display("latching_relay_bank_sequencer_test failed");
    end
    $finish;
  end

endmodule
